@@ sv/deq_pkg.sv @@
// Shared types and constants for the double-ended queue.
// Used by deq_cell and double_ended_queue; no dependencies.
package deq_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = $clog2(DEPTH);

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Broadcast from the controller to every cell of the row
	typedef struct packed {
		logic             shift_r;  // push front: every cell takes its left neighbor
		logic             shift_l;  // pop front: every cell takes its right neighbor
		logic             load;     // push back: the cell at the fill count takes the value
		logic [CNT_W-1:0] cnt;      // entries held before this beat
	} cell_ctl_t;

endpackage

@@ sv/deq_cell.sv @@
// One storage cell of the queue row: holds one entry and trades it with its neighbors.
// Depends on deq_pkg.
module deq_cell
	import deq_pkg::*;
(
	input  logic              clk,
	input  logic [IDX_W-1:0]  idx,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] push_data,
	input  logic [DATA_W-1:0] left_data,
	input  logic [DATA_W-1:0] right_data,
	input  logic [DATA_W-1:0] tap_in,
	output logic [DATA_W-1:0] data,
	output logic [DATA_W-1:0] tap_out
);

	logic [DATA_W-1:0] data_q;
	logic              at_fill;
	logic              at_back;

	assign at_fill = ({1'b0, idx} == ctl.cnt);
	assign at_back = (({1'b0, idx} + CNT_W'(1)) == ctl.cnt);

	// Entry register: shift either way or take a pushed value
	always_ff @(posedge clk) begin
		if (ctl.shift_r) begin
			data_q <= left_data;
		end else if (ctl.shift_l) begin
			data_q <= right_data;
		end else if (ctl.load && at_fill) begin
			data_q <= push_data;
		end
	end

	assign data = data_q;

	// Back-entry read: only the last occupied cell drives the tap chain
	assign tap_out = tap_in | (at_back ? data_q : '0);

endmodule

@@ sv/double_ended_queue.sv @@
// Top level of the double-ended queue: count control, row of deq_cell, result register.
// Depends on deq_pkg and deq_cell.
//
//  channel   signals                                     direction
//  command   start, busy, op, data_value                 in (busy out)
//  result    done, popped_value, status, length, is_empty out
//
// One operation per cycle; busy stays low. The result of a command taken at
// one edge is shown with done for the following cycle. Entries sit in a row
// of cells with the front in cell 0; a front push or pop shifts the whole row
// by one cell in that cycle.
// Reset clears the count and the result strobe; cell contents are not reset.
// The receiver cannot stall, so results never back up.
module double_ended_queue
	import deq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               op,
	input  logic signed [DATA_W-1:0] data_value,
	output logic                     done,
	output logic signed [DATA_W-1:0] popped_value,
	output logic [1:0]               status,
	output logic [CNT_W-1:0]         length,
	output logic                     is_empty
);

	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_next;
	logic              full;
	logic              empty;
	op_t               op_c;
	cell_ctl_t         ctl;
	status_t           status_c;
	logic [DATA_W-1:0] popped_c;
	logic              take;

	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [DATA_W-1:0] tap       [DEPTH+1];

	logic                     done_q;
	logic [DATA_W-1:0]        popped_q;
	status_t                  status_q;
	logic [CNT_W-1:0]         length_q;

	assign busy  = 1'b0;
	assign take  = start && !busy;
	assign op_c  = op_t'(op);
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);

	// Decode the command into a cell broadcast and the result fields
	always_comb begin
		ctl         = '0;
		ctl.cnt     = cnt_q;
		cnt_next    = cnt_q;
		status_c    = ST_DONE;
		popped_c    = '0;
		case (op_c)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (full) begin
					status_c = ST_FULL;
				end else begin
					ctl.shift_r = take && (op_c == OP_PUSH_FRONT);
					ctl.load    = take && (op_c == OP_PUSH_BACK);
					cnt_next    = cnt_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (empty) begin
					status_c = ST_EMPTY;
					popped_c = '1;
				end else begin
					ctl.shift_l = take && (op_c == OP_POP_FRONT);
					popped_c    = (op_c == OP_POP_FRONT) ? cell_data[0] : tap[DEPTH];
					cnt_next    = cnt_q - CNT_W'(1);
				end
			end
			default: begin
				status_c = ST_DONE;
			end
		endcase
	end

	// Row of cells: front at cell 0, back at cell cnt-1
	assign tap[0] = '0;
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = data_value;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end
		deq_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(i)),
			.ctl        (ctl),
			.push_data  (data_value),
			.left_data  (left_d),
			.right_data (right_d),
			.tap_in     (tap[i]),
			.data       (cell_data[i]),
			.tap_out    (tap[i+1])
		);
	end

	// Fill count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= take;
			if (take) begin
				cnt_q <= cnt_next;
			end
		end
	end

	// Result beat payload
	always_ff @(posedge clk) begin
		if (take) begin
			popped_q <= popped_c;
			status_q <= status_c;
			length_q <= cnt_next;
		end
	end

	assign done         = done_q;
	assign popped_value = popped_q;
	assign status       = status_q;
	assign length       = length_q;
	assign is_empty     = (length_q == '0);

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking bench for double_ended_queue: directed edge cases, then random bursts,
// with a scoreboard class that tracks a ring model of the queue and checks every result.
// Depends on deq_pkg and the double_ended_queue RTL.
module testbench;
	import deq_pkg::*;

	localparam int N_RANDOM    = 1750;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic signed [DATA_W-1:0] popped;
		status_t                  st;
		logic [CNT_W-1:0]         len;
		logic                     empty;
	} deq_result_t;

	// Ring model of the queue plus the list of results still owed by the block
	class deq_scoreboard;
		logic [DATA_W-1:0] ring [DEPTH];
		int unsigned       head;
		int unsigned       fill;
		deq_result_t       awaited [$];
		int unsigned       errors;

		function new();
			head   = 0;
			fill   = 0;
			errors = 0;
		endfunction

		// Apply one accepted command beat to the model and queue its result
		function void note_command(op_t o, logic [DATA_W-1:0] v);
			deq_result_t r;
			r.popped = '0;
			r.st     = ST_DONE;
			case (o)
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					if (fill >= DEPTH) begin
						r.st = ST_FULL;
					end else if (o == OP_PUSH_FRONT) begin
						head       = (head + DEPTH - 1) % DEPTH;
						ring[head] = v;
						fill++;
					end else begin
						ring[(head + fill) % DEPTH] = v;
						fill++;
					end
				end
				default: begin
					if (fill == 0) begin
						r.st     = ST_EMPTY;
						r.popped = '1;
					end else if (o == OP_POP_FRONT) begin
						r.popped = ring[head];
						head     = (head + 1) % DEPTH;
						fill--;
					end else begin
						r.popped = ring[(head + fill - 1) % DEPTH];
						fill--;
					end
				end
			endcase
			// an emptied queue restarts at slot zero
			if (fill == 0)
				head = 0;
			r.len   = CNT_W'(fill);
			r.empty = (fill == 0);
			awaited.push_back(r);
		endfunction

		// Compare one result beat against the oldest expectation
		function void check_result(logic [DATA_W-1:0] popped, logic [1:0] st,
		                           logic [CNT_W-1:0] len, logic empty);
			deq_result_t r;
			if (awaited.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
				return;
			end
			r = awaited.pop_front();
			if (popped !== r.popped) begin
				$error("popped_value: expected %0d, got %0d", r.popped, $signed(popped));
				errors++;
			end
			if (st !== r.st) begin
				$error("status: expected %0d, got %0d", r.st, st);
				errors++;
			end
			if (len !== r.len) begin
				$error("length: expected %0d, got %0d", r.len, len);
				errors++;
			end
			if (empty !== r.empty) begin
				$error("is_empty: expected %0d, got %0d", r.empty, empty);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     start      = 1'b0;
	logic                     busy;
	logic [1:0]               op         = OP_PUSH_FRONT;
	logic signed [DATA_W-1:0] data_value = '0;
	logic                     done;
	logic signed [DATA_W-1:0] popped_value;
	logic [1:0]               status;
	logic [CNT_W-1:0]         length;
	logic                     is_empty;

	deq_scoreboard sb = new();
	int unsigned   cycles = 0;

	double_ended_queue i_dut (.*);

	always #2 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Monitor: results first, then the command taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(popped_value, status, length, is_empty);
			if (start && !busy)
				sb.note_command(op_t'(op), data_value);
		end
	end

	// Present one command beat from a falling edge until it is taken
	task automatic send_cmd(op_t o, logic [DATA_W-1:0] v);
		start      <= 1'b1;
		op         <= o;
		data_value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic pause(int unsigned n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Hold the command side until every owed result has come back
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(11))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Random op with a given chance, in percent, of being a push
	function automatic op_t pick_op(int unsigned push_pct);
		if ($urandom_range(99) < push_pct)
			return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
		return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
	endfunction

	initial begin
		int unsigned sent;
		int unsigned burst;
		int unsigned push_pct;
		bit          drained;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: pops on empty queue, extreme values, last entry popped
		send_cmd(OP_POP_FRONT, 32'h1234_5678);
		send_cmd(OP_POP_BACK, '1);
		send_cmd(OP_PUSH_FRONT, 32'h7FFF_FFFF);
		send_cmd(OP_PUSH_BACK, 32'h8000_0000);
		send_cmd(OP_POP_FRONT, '0);
		send_cmd(OP_POP_BACK, '0);
		// Fill to the brim, front pushes wrap the ring, then refused pushes
		for (int i = 0; i < DEPTH; i++)
			send_cmd((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, (i < 4) ? pick_value() : $urandom);
		send_cmd(OP_PUSH_FRONT, 32'hDEAD_BEEF);
		send_cmd(OP_PUSH_BACK, 32'h0BAD_F00D);
		drain();

		// Random bursts; each burst leans toward filling or emptying, or is balanced
		sent    = 0;
		drained = 1'b0;
		while (sent < N_RANDOM) begin
			burst    = $urandom_range(1, 40);
			push_pct = $urandom_range(2) == 0 ? 50 : ($urandom_range(1) ? 80 : 20);
			for (int i = 0; i < burst && sent < N_RANDOM; i++) begin
				send_cmd(pick_op(push_pct), pick_value());
				sent++;
			end
			if ($urandom_range(3) != 0)
				pause($urandom_range(1, 8));
			if (!drained && sent >= N_RANDOM / 2) begin
				drain();
				drained = 1'b1;
			end
		end

		drain();
		repeat (4) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
